### hw/rtl/btps_pkg.sv
// Package for the buzzer tone pattern sequencer: pattern ROM, state record and function codes.
// Used by btps_ram consumers and by buzzer_tone_pattern_sequencer_top. No dependencies.
package btps_pkg;

  localparam int NUM_PATTERNS      = 6;
  localparam int MAX_PATTERN_WORDS = 12;
  localparam int ROM_ROWS          = 8;
  localparam int ROM_COLS          = 16;

  localparam int FREQ_W = 12;
  localparam int DUR_W  = 8;
  localparam int SEL_W  = 3;
  localparam int POS_W  = 4;
  localparam int FUNC_W = 2;

  // Function codes of an input beat; code three is unused.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_PLAY = 2'd1,
    FUNC_MUTE = 2'd2
  } func_e;

  // Sequencer state record, kept in the state memory.
  typedef struct packed {
    logic              active;
    logic [SEL_W-1:0]  pattern_index;
    logic [POS_W-1:0]  word_position;
    logic [DUR_W-1:0]  remaining_ms;
    logic              mute_flag;
    logic [FREQ_W-1:0] current_freq;
  } state_t;

  localparam int STATE_W = $bits(state_t);

  // Pattern words: frequency and duration pairs, rows past the defined patterns are silent.
  localparam logic [FREQ_W-1:0] ROM_WORDS [ROM_ROWS][ROM_COLS] = '{
    '{12'd2000, 12'd30, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
      12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{12'd1000, 12'd80, 12'd0, 12'd30, 12'd2000, 12'd80, 12'd0, 12'd0,
      12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{12'd2000, 12'd80, 12'd0, 12'd30, 12'd1000, 12'd80, 12'd0, 12'd0,
      12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{12'd1500, 12'd60, 12'd0, 12'd40, 12'd2500, 12'd60, 12'd0, 12'd40,
      12'd3500, 12'd80, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{12'd400, 12'd150, 12'd0, 12'd80, 12'd400, 12'd150, 12'd0, 12'd0,
      12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{12'd800, 12'd100, 12'd0, 12'd100, 12'd800, 12'd100, 12'd0, 12'd0,
      12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
    '{default: 12'd0},
    '{default: 12'd0}
  };

  localparam logic [POS_W-1:0] ROM_LENGTH [ROM_ROWS] = '{
    4'd4, 4'd8, 4'd8, 4'd12, 4'd8, 4'd8, 4'd0, 4'd0
  };

  // Pattern length, limited to the longest pattern allowed.
  function automatic logic [POS_W-1:0] pattern_len(input logic [SEL_W-1:0] pat);
    logic [POS_W-1:0] len;
    len = ROM_LENGTH[pat];
    if (int'(len) > MAX_PATTERN_WORDS) begin
      len = POS_W'(MAX_PATTERN_WORDS);
    end
    return len;
  endfunction

endpackage

### hw/rtl/btps_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used by the buzzer tone pattern sequencer for its state record.
module btps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; returns the old contents on a same-cycle write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/buzzer_tone_pattern_sequencer_top.sv
// Buzzer tone pattern sequencer: plays fixed beep patterns on tick, play and mute beats.
// Depends on btps_pkg and btps_ram.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per command: a one
//   millisecond tick, a play request with a pattern select, or a mute setting.
//   Output channel (out_valid_o / out_ready_i) returns exactly one beat per
//   input beat: the frequency now driven, the playing and muted flags, and a
//   finished flag that is high when a pattern ended on that beat.
//   An accepted beat passes the compute stage register, then the output register.
//   Throughput is one beat per cycle while the receiver takes results: the
//   state record is read from the state memory in the accept cycle, written back
//   as the beat leaves the compute stage, and forwarded to a beat directly behind.
//   At reset the sequencer is idle, unmuted and silent; the state memory is not
//   cleared, a written flag makes it read as all zero until its first write.
//   When the receiver stalls, the result holds in the output register, one
//   more beat waits in the compute stage, and in_ready_o then falls.
module buzzer_tone_pattern_sequencer_top
  import btps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [SEL_W-1:0]  pattern_select_i,
  input  logic              mute_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [FREQ_W-1:0] freq_hz_o,
  output logic              playing_o,
  output logic              muted_o,
  output logic              finished_o
);

  logic              in_fire;
  logic              s2_fire;
  logic              s2_advance;

  logic              s2_valid_q;
  logic [FUNC_W-1:0] s2_func_q;
  logic [SEL_W-1:0]  s2_sel_q;
  logic              s2_mv_q;

  logic              fwd_q;
  state_t            fwd_data_q;
  logic              ram_written_q;
  logic [STATE_W-1:0] ram_rdata;

  state_t            cur_state;
  state_t            nxt_state;
  logic              finished_d;
  logic [DUR_W-1:0]  rem_dec;
  logic [POS_W-1:0]  pos_next;
  logic [FREQ_W-1:0] rom_f;
  logic [FREQ_W-1:0] rom_d;

  logic              out_valid_q;
  logic [FREQ_W-1:0] freq_q;
  logic              playing_q;
  logic              muted_q;
  logic              finished_q;

  // Handshake: the compute stage moves on when the output register is free or drains.
  assign s2_advance = !out_valid_q || out_ready_i;
  assign s2_fire    = s2_valid_q && s2_advance;
  assign in_ready_o = !s2_valid_q || s2_advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // State memory: one record, read on accept, written back when the beat completes.
  btps_ram #(
    .WIDTH (STATE_W),
    .DEPTH (1)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s2_fire),
    .waddr_i (1'b0),
    .wdata_i (nxt_state),
    .re_i    (in_fire),
    .raddr_i (1'b0),
    .rdata_o (ram_rdata)
  );

  // Compute stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q    <= 1'b0;
      fwd_q         <= 1'b0;
      ram_written_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s2_valid_q <= 1'b1;
        fwd_q      <= s2_fire;
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_fire) begin
        ram_written_q <= 1'b1;
      end
    end
  end

  // Compute stage payload and the forwarded copy of the last write.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s2_func_q <= func_i;
      s2_sel_q  <= pattern_select_i;
      s2_mv_q   <= mute_value_i;
    end
    if (s2_fire) begin
      fwd_data_q <= nxt_state;
    end
  end

  // The record the memory read missed is forwarded; an unwritten memory reads as reset.
  always_comb begin
    if (fwd_q) begin
      cur_state = fwd_data_q;
    end else if (ram_written_q) begin
      cur_state = state_t'(ram_rdata);
    end else begin
      cur_state = '0;
    end
  end

  // Pattern ROM lookups for the next pair of the running pattern.
  assign pos_next = cur_state.word_position + POS_W'(1);
  assign rom_f    = ROM_WORDS[cur_state.pattern_index][cur_state.word_position];
  assign rom_d    = ROM_WORDS[cur_state.pattern_index][pos_next];
  assign rem_dec  = (cur_state.remaining_ms != '0) ? cur_state.remaining_ms - DUR_W'(1) : '0;

  // Read-modify-write of the state record for one beat.
  always_comb begin
    nxt_state  = cur_state;
    finished_d = 1'b0;
    case (func_e'(s2_func_q))
      FUNC_TICK: begin
        if (cur_state.active) begin
          nxt_state.remaining_ms = rem_dec;
          if (rem_dec == '0) begin
            if ((cur_state.word_position >= pattern_len(cur_state.pattern_index)) ||
                ((rom_f == '0) && (rom_d == '0))) begin
              nxt_state.current_freq = '0;
              nxt_state.active       = 1'b0;
              finished_d             = 1'b1;
            end else begin
              nxt_state.current_freq  = rom_f;
              nxt_state.remaining_ms  = rom_d[DUR_W-1:0];
              nxt_state.word_position = cur_state.word_position + POS_W'(2);
            end
          end
        end
      end
      FUNC_PLAY: begin
        if (!cur_state.mute_flag && (int'(s2_sel_q) < NUM_PATTERNS)) begin
          nxt_state.pattern_index = s2_sel_q;
          nxt_state.active        = 1'b1;
          nxt_state.current_freq  = ROM_WORDS[s2_sel_q][0];
          nxt_state.remaining_ms  = ROM_WORDS[s2_sel_q][1][DUR_W-1:0];
          nxt_state.word_position = POS_W'(2);
        end
      end
      FUNC_MUTE: begin
        nxt_state.mute_flag = s2_mv_q;
        if (s2_mv_q) begin
          nxt_state.current_freq = '0;
          nxt_state.active       = 1'b0;
        end
      end
      default: begin
        nxt_state = cur_state;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_advance) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      freq_q     <= nxt_state.current_freq;
      playing_q  <= nxt_state.active;
      muted_q    <= nxt_state.mute_flag;
      finished_q <= finished_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign freq_hz_o   = freq_q;
  assign playing_o   = playing_q;
  assign muted_o     = muted_q;
  assign finished_o  = finished_q;

`ifndef ASSERT_OFF
  // A finished pattern leaves the sequencer idle.
  a_finished_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && finished_q) |-> !playing_q)
    else $error("finished result while still playing");

  // An idle sequencer drives silence.
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !playing_q) |-> (freq_q == '0))
    else $error("tone driven while idle");

  // Muting drops any pattern.
  a_muted_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && muted_q) |-> !playing_q)
    else $error("pattern active while muted");

  // Forwarding is only selected behind a write-back in the previous cycle.
  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && fwd_q && $rose(s2_valid_q) == 1'b0 && $past(in_fire)) |-> $past(s2_fire))
    else $error("forwarded state without a preceding write-back");
`endif

endmodule
